>>> rtl/tta_pkg.sv
// Shared constants and types for the thermistor temperature alarm.
// Fixed-point widths, Horner coefficients, colour codes, core status struct.
// No dependencies.
package tta_pkg;

  localparam int AdcBits   = 12;
  localparam int VoltW     = 22;
  localparam int AccW      = 32;
  localparam int FracBits  = 20;
  localparam int TempShift = 15;
  localparam int TempW     = 16;
  localparam int ThrW      = 8;
  localparam int ProdW     = AccW + 1 + VoltW + 1;

  // 3.3 V in Q20
  localparam logic [VoltW-1:0] VrefQ20 = 22'd3460301;

  // a0..a4, signed Q12.20
  localparam logic signed [AccW-1:0] Coef [5] = '{
    -32'sd443842403,
    32'sd495850304,
    -32'sd208545094,
    32'sd51060629,
    -32'sd1215042
  };

  typedef enum logic [1:0] {
    ColourNormal = 2'd0,
    ColourHot    = 2'd1,
    ColourCold   = 2'd2
  } colour_e;

  localparam logic [0:0] RegDeltaThreshold = 1'b0;

  typedef struct packed {
    logic idle;
    logic done;
  } tta_stat_t;

endpackage

>>> rtl/tta_core.sv
// Iterative linearization core: voltage scaling and Horner evaluation on one
// shared multiplier under a small sequencer. Depends on tta_pkg.
module tta_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tta_pkg::AdcBits-1:0] code_i,
  input  logic                       take_i,
  output tta_pkg::tta_stat_t         stat_o,
  output logic [tta_pkg::TempW-1:0]  temp_o
);
  import tta_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StVmul,
    StVload,
    StMul,
    StAdd,
    StDone
  } state_e;

  state_e                  state_q;
  logic [AdcBits-1:0]      code_q;
  logic [VoltW-1:0]        volt_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [ProdW-1:0] prod_q;
  logic [2:0]              k_q;

  logic signed [AccW:0]    mul_a;
  logic signed [VoltW:0]   mul_b;
  logic signed [ProdW-1:0] prod_rnd;
  logic signed [ProdW-1:0] prod_shr;
  logic signed [AccW-1:0]  acc_next;

  always_comb begin
    if (state_q == StVmul) begin
      mul_a = (AccW+1)'($unsigned(code_q));
      mul_b = {1'b0, VrefQ20};
    end else begin
      mul_a = {acc_q[AccW-1], acc_q};
      mul_b = {1'b0, volt_q};
    end
  end

  // truncate toward zero on the right shift
  assign prod_rnd = prod_q[ProdW-1] ? prod_q + ProdW'((64'd1 << FracBits) - 64'd1) : prod_q;
  assign prod_shr = prod_rnd >>> FracBits;
  assign acc_next = prod_shr[AccW-1:0] + Coef[k_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      k_q     <= 3'd0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StVmul;
          end
        end
        StVmul: begin
          state_q <= StVload;
        end
        StVload: begin
          k_q     <= 3'd3;
          state_q <= StMul;
        end
        StMul: begin
          state_q <= StAdd;
        end
        StAdd: begin
          if (k_q == 3'd0) begin
            state_q <= StDone;
          end else begin
            k_q     <= k_q - 3'd1;
            state_q <= StMul;
          end
        end
        StDone: begin
          if (take_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      code_q <= code_i;
    end
    if (state_q == StVmul || state_q == StMul) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == StVload) begin
      volt_q <= prod_q[AdcBits +: VoltW];
      acc_q  <= Coef[4];
    end
    if (state_q == StAdd) begin
      acc_q <= acc_next;
    end
  end

  assign stat_o.idle = (state_q == StIdle);
  assign stat_o.done = (state_q == StDone);
  assign temp_o = acc_q[AccW-1] ? '0 : acc_q[TempShift +: TempW];

endmodule

>>> rtl/thermistor_temp_alarm.sv
// Thermistor temperature alarm top level: stream ports, APB register,
// baseline tracking and colour classification. Depends on tta_pkg, tta_core.
//
// Usage: one transaction on the s_axis side carries a raw ADC sample in
// tdata and the restart-baseline flag in tuser. One transaction on the
// m_axis side returns the temperature in 1/32 degree C in tdata and the
// colour code (normal, hot, cold) in tuser, one result per sample, in order.
// After the accepting edge the core performs one voltage multiply and four
// multiply/add Horner steps on the single shared multiplier in tta_core;
// the output register is then loaded and m_axis_tvalid rises.
// s_axis_tready is high only while the core is idle, so a new sample is
// not accepted until the core has handed on the previous result.
// The result sits in an output register, so a new sample is accepted while
// it waits; if the receiver stalls, the core holds its finished value and
// stays busy until the output register frees up.
// The APB port holds delta_threshold at address 0 (reset value 2). Reset
// clears the baseline and the have-baseline flag, so the first sample after
// reset, or any sample flagged in tuser, becomes the new baseline.
module thermistor_temp_alarm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] adc_code
  input  logic        s_axis_tuser,   // [0] restart_baseline
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] temp_code
  output logic [1:0]  m_axis_tuser,   // [1:0] colour
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tta_pkg::*;

  tta_stat_t          stat;
  logic [TempW-1:0]   temp;
  logic               start;
  logic               take;
  logic               restart_q;
  logic               have_base_q;
  logic [TempW-1:0]   base_q;
  logic [ThrW-1:0]    thr_q;
  logic               out_valid_q;
  logic [TempW-1:0]   out_temp_q;
  colour_e            out_colour_q;
  logic [TempW-1:0]   base_d;
  logic               latch;
  logic [TempW:0]     band;
  logic [TempW:0]     hi_lim;
  logic [TempW:0]     t_plus;
  colour_e            colour;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegDeltaThreshold) ? 32'(thr_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrW'(2);
    end else if (psel && penable && pwrite && pready && paddr[2] == RegDeltaThreshold) begin
      thr_q <= pwdata[ThrW-1:0];
    end
  end

  assign s_axis_tready = stat.idle;
  assign start = s_axis_tvalid && stat.idle;
  assign take  = stat.done && (!out_valid_q || m_axis_tready);

  tta_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .code_i (s_axis_tdata[AdcBits-1:0]),
    .take_i (take),
    .stat_o (stat),
    .temp_o (temp)
  );

  assign latch  = !have_base_q || restart_q;
  assign base_d = latch ? temp : base_q;
  assign band   = (TempW+1)'({thr_q, 5'd0});
  assign hi_lim = {1'b0, base_d} + band;
  assign t_plus = {1'b0, temp} + band;

  always_comb begin
    priority if ({1'b0, temp} > hi_lim) begin
      colour = ColourHot;
    end else if (t_plus < {1'b0, base_d}) begin
      colour = ColourCold;
    end else begin
      colour = ColourNormal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_base_q <= 1'b0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        have_base_q <= 1'b1;
        base_q      <= base_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      restart_q <= s_axis_tuser;
    end
    if (take) begin
      out_temp_q   <= temp;
      out_colour_q <= colour;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_temp_q;
  assign m_axis_tuser  = out_colour_q;

endmodule

>>> dv/thermistor_temp_alarm_tb.sv
// Testbench for thermistor_temp_alarm: streams ADC samples in, checks each temperature
// and colour reading against a fixed-point predictor or typed table value, and writes
// the threshold over APB. Depends on tta_pkg and the thermistor_temp_alarm RTL.
`timescale 1ns / 100ps

module thermistor_temp_alarm_tb;
  import tta_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int RandomPhases = 6;
  localparam int SamplesPerPhase = 100;
  localparam logic [2:0] AddrDeltaThreshold = {RegDeltaThreshold, 2'b00};

  // Q12.20 polynomial coefficients a0..a4 and the 3.3 V reference in Q20
  localparam longint PolyA0 = -64'sd443842403;
  localparam longint PolyA1 = 64'sd495850304;
  localparam longint PolyA2 = -64'sd208545094;
  localparam longint PolyA3 = 64'sd51060629;
  localparam longint PolyA4 = -64'sd1215042;
  localparam longint VoltRefQ20 = 64'sd3460301;

  typedef enum logic {RowSample, RowThreshold} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [11:0] adc;
    logic        restart;
    logic [7:0]  threshold;
    logic        typed;
    logic [15:0] temp;
    colour_e     colour;
  } directed_row_t;

  typedef struct packed {
    logic [15:0] temp;
    colour_e     colour;
  } reading_t;

  localparam int DirectedRows = 24;
  localparam directed_row_t DirectedTable [DirectedRows] = '{
    '{RowSample,    12'd0,    1'b0, 8'd0,   1'b1, 16'd0, ColourNormal},
    '{RowSample,    12'd1024, 1'b0, 8'd0,   1'b1, 16'd0, ColourNormal},
    '{RowSample,    12'd4095, 1'b0, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd1,    1'b0, 8'd0,   1'b1, 16'd0, ColourNormal},
    '{RowSample,    12'd2048, 1'b1, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd2049, 1'b0, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd0,    1'b0, 8'd0,   1'b1, 16'd0, ColourCold},
    '{RowSample,    12'd4095, 1'b1, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd2730, 1'b0, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd1365, 1'b0, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd4094, 1'b0, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd2047, 1'b0, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd1900, 1'b1, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd1880, 1'b0, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowThreshold, 12'd0,    1'b0, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd3000, 1'b1, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd3000, 1'b0, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd3001, 1'b0, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd2999, 1'b0, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowThreshold, 12'd0,    1'b0, 8'd255, 1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd0,    1'b1, 8'd0,   1'b1, 16'd0, ColourNormal},
    '{RowSample,    12'd4095, 1'b0, 8'd0,   1'b0, 16'd0, ColourNormal},
    '{RowSample,    12'd1000, 1'b0, 8'd0,   1'b1, 16'd0, ColourNormal},
    '{RowSample,    12'd2600, 1'b0, 8'd0,   1'b0, 16'd0, ColourNormal}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [11:0] adc_code
  logic        s_axis_tuser = 1'b0; // [0] restart_baseline
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] temp_code
  logic [1:0]  m_axis_tuser;        // [1:0] colour
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [7:0]  alarm_threshold;
  logic [15:0] baseline_temp;
  logic        baseline_valid;
  reading_t    expected_readings [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          sink_hold = 0;
  bit          quiet_phase = 1'b0;

  thermistor_temp_alarm uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint shift_toward_zero(longint x, int sh);
    if (x < 0) return -((-x) >> sh);
    return x >> sh;
  endfunction

  function automatic logic [15:0] adc_to_temp_code(logic [11:0] adc);
    longint volt;
    longint acc;
    longint coef [4];
    longint t;
    coef = '{PolyA0, PolyA1, PolyA2, PolyA3};
    volt = (longint'(adc) * VoltRefQ20) >> 12;
    acc = PolyA4;
    for (int k = 3; k >= 0; k--) begin
      acc = shift_toward_zero(acc * volt, 20) + coef[k];
    end
    t = shift_toward_zero(acc, 15);
    if (t < 0) return 16'd0;
    if (t > 65535) return 16'hffff;
    return t[15:0];
  endfunction

  function automatic reading_t predict_reading(logic [11:0] adc, logic restart);
    reading_t r;
    int band;
    r.temp = adc_to_temp_code(adc);
    if (!baseline_valid || restart) begin
      baseline_temp = r.temp;
      baseline_valid = 1'b1;
    end
    band = int'(alarm_threshold) * 32;
    if (int'(r.temp) > int'(baseline_temp) + band) r.colour = ColourHot;
    else if (int'(r.temp) < int'(baseline_temp) - band) r.colour = ColourCold;
    else r.colour = ColourNormal;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_sample(input logic [11:0] adc, input logic restart, input logic typed,
                             input logic [15:0] typed_temp, input colour_e typed_colour);
    int gap;
    reading_t r;
    gap = quiet_phase ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0000, adc};
    s_axis_tuser <= restart;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_reading(adc, restart);
    if (typed) begin
      r.temp = typed_temp;
      r.colour = typed_colour;
    end
    expected_readings.push_back(r);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrDeltaThreshold;
    pwdata <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    alarm_threshold = value;
  endtask

  initial begin
    int base_adc;
    int adc;
    logic restart;
    alarm_threshold = 8'd2;
    baseline_temp = 16'd0;
    baseline_valid = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedTable[i]) begin
      if (DirectedTable[i].kind == RowThreshold) begin
        drain_results();
        write_threshold(DirectedTable[i].threshold);
      end else begin
        send_sample(DirectedTable[i].adc, DirectedTable[i].restart, DirectedTable[i].typed,
                    DirectedTable[i].temp, DirectedTable[i].colour);
      end
    end

    base_adc = 2048;
    for (int p = 0; p < RandomPhases; p++) begin
      drain_results();
      quiet_phase = (p == 2);
      if (p == 0) write_threshold(8'd0);
      else if (p == 1) write_threshold(8'd255);
      else write_threshold(8'($urandom_range(0, 255)));
      for (int n = 0; n < SamplesPerPhase; n++) begin
        restart = ($urandom_range(0, 15) == 0);
        // half the samples wander near base_adc (the last restart code) to hit the band edges
        if ($urandom_range(0, 1) == 0) begin
          adc = base_adc + $urandom_range(0, 400) - 200;
          if (adc < 0) adc = 0;
          if (adc > 4095) adc = 4095;
        end else begin
          adc = $urandom_range(0, 4095);
        end
        if (restart) base_adc = adc;
        send_sample(12'(adc), restart, 1'b0, 16'd0, ColourNormal);
      end
    end

    drain_results();
    repeat (24) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("thermistor_temp_alarm verification clean");
    end else begin
      $display("thermistor_temp_alarm verification failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      m_axis_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet_phase && $urandom_range(0, 7) == 0) sink_hold <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    reading_t r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected transaction: temp_code %0d colour %0d", m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        r = expected_readings.pop_front();
        if (m_axis_tdata !== r.temp) begin
          $error("temp_code mismatch: expected %0d, actual %0d", r.temp, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser !== r.colour) begin
          $error("colour mismatch: expected %0d, actual %0d", r.colour, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("thermistor_temp_alarm verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> filelist.f
rtl/tta_pkg.sv
rtl/tta_core.sv
rtl/thermistor_temp_alarm.sv
dv/thermistor_temp_alarm_tb.sv
